// ===== design/qdec_pkg.sv =====
// shared types, constants and transition decode for the quadrature decoder
`default_nettype none

package qdec_pkg;

    localparam int MAX_CHANNELS      = 4;
    localparam int DEF_CHANNELS      = 4;
    localparam int DEF_COUNT_WIDTH   = 32;
    localparam int OUT_WIDTH         = 32;
    localparam int WINDOW_WIDTH      = 17;
    localparam int CFG_WIDTH         = 16;
    localparam int ELAPSED_WIDTH     = 10;

    localparam logic [CFG_WIDTH-1:0]    WINDOW_US_RESET   = 16'd1000;
    localparam logic [MAX_CHANNELS-1:0] INVERT_MASK_RESET = 4'b1000;

    typedef enum logic [0:0] {
        REG_WINDOW_US   = 1'b0,
        REG_INVERT_MASK = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MOVE_HOLD,
        MOVE_UP,
        MOVE_DOWN,
        MOVE_ILLEGAL
    } move_t;

    typedef struct packed {
        logic load;
        logic commit;
    } lane_ctrl_t;

    // previous ab in the upper two bits, current ab in the lower two
    function automatic move_t decode_move(input logic [1:0] prev, input logic [1:0] cur);
        move_t m;
        case ({prev, cur})
            4'b0010, 4'b0100, 4'b1011, 4'b1101: m = MOVE_UP;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: m = MOVE_DOWN;
            4'b0011, 4'b0110, 4'b1001, 4'b1100: m = MOVE_ILLEGAL;
            default:                            m = MOVE_HOLD;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/qdec_lane.sv =====
// one decoder lane: count update, then windowed delta latch
`default_nettype none

module qdec_lane
    import qdec_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lane_ctrl_t             ctrl,
    input  wire logic                   phase_a,
    input  wire logic                   phase_b,
    input  wire logic                   index_line,
    input  wire logic                   invert,
    output logic [COUNT_WIDTH-1:0]      position,
    output logic [COUNT_WIDTH-1:0]      delta,
    output logic                        illegal
);

    logic [1:0]             last_phases_reg;
    logic                   last_index_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_base;
    logic                   illegal_reg;
    logic                   illegal_next;
    logic [COUNT_WIDTH-1:0] window_start_reg;
    logic [COUNT_WIDTH-1:0] delta_reg;
    logic [COUNT_WIDTH-1:0] delta_next;
    logic [1:0]             cur_phases;
    move_t                  move;

    assign cur_phases = {phase_a, phase_b};
    assign move       = decode_move(last_phases_reg, cur_phases);

    always_comb
    begin
        count_base   = (index_line && !last_index_reg) ? '0 : count_reg;
        illegal_next = 1'b0;
        case (move)
            MOVE_UP:      count_next = count_base + COUNT_WIDTH'(1);
            MOVE_DOWN:    count_next = count_base - COUNT_WIDTH'(1);
            MOVE_ILLEGAL:
            begin
                count_next   = count_base;
                illegal_next = 1'b1;
            end
            default:      count_next = count_base;
        endcase
    end

    // negation folded into the operand order
    assign delta_next = invert ? (window_start_reg - count_reg) : (count_reg - window_start_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phases_reg  <= '0;
            last_index_reg   <= 1'b0;
            count_reg        <= '0;
            illegal_reg      <= 1'b0;
            window_start_reg <= '0;
            delta_reg        <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                last_phases_reg <= cur_phases;
                last_index_reg  <= index_line;
                count_reg       <= count_next;
                illegal_reg     <= illegal_next;
            end
            if (ctrl.commit)
            begin
                window_start_reg <= count_reg;
                delta_reg        <= delta_next;
            end
        end
    end

    assign position = count_reg;
    assign delta    = delta_reg;
    assign illegal  = illegal_reg;

endmodule

`default_nettype wire

// ===== design/qdec_timer.sv =====
// shared window timer for all lanes
`default_nettype none

module qdec_timer
    import qdec_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire logic [ELAPSED_WIDTH-1:0] elapsed_us,
    input  wire logic [CFG_WIDTH-1:0]     window_us,
    output logic                          closed,
    output logic [WINDOW_WIDTH-1:0]       window_length
);

    logic [WINDOW_WIDTH-1:0] acc_reg;
    logic [WINDOW_WIDTH-1:0] acc_sum;
    logic [WINDOW_WIDTH-1:0] latched_reg;
    logic                    closed_reg;
    logic                    closed_next;

    assign acc_sum     = acc_reg + WINDOW_WIDTH'(elapsed_us);
    assign closed_next = acc_sum >= WINDOW_WIDTH'(window_us);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            latched_reg <= '0;
            closed_reg  <= 1'b0;
        end
        else if (load)
        begin
            closed_reg <= closed_next;
            if (closed_next)
            begin
                acc_reg     <= '0;
                latched_reg <= acc_sum;
            end
            else
            begin
                acc_reg <= acc_sum;
            end
        end
    end

    assign closed        = closed_reg;
    assign window_length = latched_reg;

endmodule

`default_nettype wire

// ===== design/multi_channel_quadrature_decoder.sv =====
// top level: config registers, decoder lanes, window timer and output register
`default_nettype none

// Decodes up to four quadrature encoders with index lines. Each input word is one
// sample of every channel's A, B and index levels plus the microseconds since the
// previous sample; each sample yields exactly one output word with the per-channel
// positions, the deltas latched at the last window close, the window length, a
// window-closed flag and per-channel illegal-transition flags. One word is taken
// every clock while in_stall is low; its result reaches the outputs through two
// register stages (count update in the lanes, then the output register together
// with the window delta subtract). While an output word waits under out_stall the
// whole pipeline holds and in_stall is high, so no input word is taken while the
// output stalls. The user must write window_us and invert_mask only while no
// sample is in flight; the block itself does not enforce this.
module multi_channel_quadrature_decoder
    import qdec_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [CFG_WIDTH-1:0]     cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [MAX_CHANNELS-1:0]  phase_a,
    input  wire logic [MAX_CHANNELS-1:0]  phase_b,
    input  wire logic [MAX_CHANNELS-1:0]  index_line,
    input  wire logic [ELAPSED_WIDTH-1:0] elapsed_us,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [OUT_WIDTH-1:0]   position_0,
    output logic signed [OUT_WIDTH-1:0]   position_1,
    output logic signed [OUT_WIDTH-1:0]   position_2,
    output logic signed [OUT_WIDTH-1:0]   position_3,
    output logic signed [OUT_WIDTH-1:0]   delta_0,
    output logic signed [OUT_WIDTH-1:0]   delta_1,
    output logic signed [OUT_WIDTH-1:0]   delta_2,
    output logic signed [OUT_WIDTH-1:0]   delta_3,
    output logic [WINDOW_WIDTH-1:0]       window_length,
    output logic                          delta_updated,
    output logic [MAX_CHANNELS-1:0]       illegal_flags
);

    logic [CFG_WIDTH-1:0]    window_us_reg;
    logic [MAX_CHANNELS-1:0] invert_mask_reg;

    logic                    advance;
    logic                    s1_valid_reg;
    logic                    out_valid_reg;
    lane_ctrl_t              lane_ctrl;
    logic                    timer_closed;
    logic [WINDOW_WIDTH-1:0] timer_window;

    logic [COUNT_WIDTH-1:0]  lane_pos     [MAX_CHANNELS];
    logic [COUNT_WIDTH-1:0]  lane_delta   [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] lane_illegal;

    logic [OUT_WIDTH-1:0]    pos_out_reg  [MAX_CHANNELS];
    logic [OUT_WIDTH-1:0]    delta_out    [MAX_CHANNELS];
    logic [WINDOW_WIDTH-1:0] window_out_reg;
    logic                    updated_out_reg;
    logic [MAX_CHANNELS-1:0] illegal_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_us_reg   <= WINDOW_US_RESET;
            invert_mask_reg <= INVERT_MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_US:   window_us_reg   <= cfg_data;
                REG_INVERT_MASK: invert_mask_reg <= cfg_data[MAX_CHANNELS-1:0];
                default:         window_us_reg   <= window_us_reg;
            endcase
        end
    end

    assign advance          = !out_valid_reg || !out_stall;
    assign in_stall         = !advance;
    assign lane_ctrl.load   = in_valid && advance;
    assign lane_ctrl.commit = advance && s1_valid_reg && timer_closed;

    qdec_timer u_timer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (lane_ctrl.load),
        .elapsed_us    (elapsed_us),
        .window_us     (window_us_reg),
        .closed        (timer_closed),
        .window_length (timer_window)
    );

    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_lane
        if (i < CHANNELS)
        begin : g_used
            qdec_lane #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_lane
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (lane_ctrl),
                .phase_a    (phase_a[i]),
                .phase_b    (phase_b[i]),
                .index_line (index_line[i]),
                .invert     (invert_mask_reg[i]),
                .position   (lane_pos[i]),
                .delta      (lane_delta[i]),
                .illegal    (lane_illegal[i])
            );
        end
        else
        begin : g_unused
            assign lane_pos[i]     = '0;
            assign lane_delta[i]   = '0;
            assign lane_illegal[i] = 1'b0;
        end
        assign delta_out[i] = OUT_WIDTH'(signed'(lane_delta[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                pos_out_reg[i] <= OUT_WIDTH'(signed'(lane_pos[i]));
            end
            window_out_reg  <= timer_window;
            updated_out_reg <= timer_closed;
            illegal_out_reg <= lane_illegal;
        end
    end

    assign out_valid     = out_valid_reg;
    assign position_0    = pos_out_reg[0];
    assign position_1    = pos_out_reg[1];
    assign position_2    = pos_out_reg[2];
    assign position_3    = pos_out_reg[3];
    assign delta_0       = delta_out[0];
    assign delta_1       = delta_out[1];
    assign delta_2       = delta_out[2];
    assign delta_3       = delta_out[3];
    assign window_length = window_out_reg;
    assign delta_updated = updated_out_reg;
    assign illegal_flags = illegal_out_reg;

`ifndef ASSERT_OFF
    a_accept_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted word did not enter the lane stage");

    a_stage_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_valid_reg)
        else $error("lane stage word lost before the output register");

    a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !s1_valid_reg |=> !out_valid_reg)
        else $error("output word repeated or invented");

    a_commit_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctrl.commit |=> out_valid_reg && delta_updated)
        else $error("deltas latched without a closed window on the output");
`endif

endmodule

`default_nettype wire
